[rtl/core/sync_length_xor_packet_deframer_macros.svh]
// Assertion macros for the sync/length/XOR packet deframer checker.
// Needs nothing else; included by the checker file.
`ifndef SYNC_LENGTH_XOR_PACKET_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_XOR_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication under reset.
`define SLXD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define SLXD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/slxd_pkg.sv]
// Shared types and constants of the sync/length/XOR packet deframer.
// No dependencies.
package slxd_pkg;

	localparam logic [31:0] SYNC_RESET   = 32'hAA55_8844;
	localparam logic [14:0] MAXLEN_RESET = 15'd4000;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_GOOD = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;

	localparam logic [2:0] HDR_LEN_LO = 3'd4;
	localparam logic [2:0] HDR_LEN_HI = 3'd5;
	localparam logic [2:0] HDR_TYPE   = 3'd6;
	localparam logic [2:0] HDR_FLAGS  = 3'd7;

	localparam logic REG_SYNC   = 1'b0;
	localparam logic REG_MAXLEN = 1'b1;

	typedef struct packed {
		logic [31:0] sync_word;
		logic [14:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [7:0]  pkt_type;
		logic [7:0]  pkt_flags;
		logic [14:0] pkt_length;
		logic [15:0] error_total;
		logic        last;
	} result_t;

endpackage

[rtl/core/slxd_apb_regs.sv]
// APB configuration registers: sync word and maximum length.
// Depends on slxd_pkg.
module slxd_apb_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output slxd_pkg::cfg_t     cfg
);

	logic [31:0] sync_word_q;
	logic [14:0] max_length_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q  <= slxd_pkg::SYNC_RESET;
			max_length_q <= slxd_pkg::MAXLEN_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				slxd_pkg::REG_SYNC: begin
					sync_word_q <= pwdata;
				end
				slxd_pkg::REG_MAXLEN: begin
					max_length_q <= pwdata[14:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			slxd_pkg::REG_SYNC:   prdata = sync_word_q;
			slxd_pkg::REG_MAXLEN: prdata = {17'd0, max_length_q};
			default:              prdata = 32'd0;
		endcase
	end

	assign cfg.sync_word  = sync_word_q;
	assign cfg.max_length = max_length_q;

endmodule

[rtl/core/slxd_parser.sv]
// Frame parser: header hunt, payload streaming, checksum and result register.
// Depends on slxd_pkg.
module slxd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  slxd_pkg::cfg_t      cfg,
	input  logic                step_valid,
	input  logic [7:0]          step_byte,
	input  logic                advance,
	output logic                res_valid,
	output slxd_pkg::result_t   res
);

	logic [2:0]  header_step_q, header_step_d;
	logic        in_payload_q, in_payload_d;
	logic [15:0] length_q, length_d;
	logic [14:0] bytes_left_q, bytes_left_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  xor_q, xor_d;
	logic [15:0] err_q, err_d;

	logic              emit;
	slxd_pkg::result_t res_d;
	logic              res_valid_s2;
	slxd_pkg::result_t res_s2;

	always_comb begin
		logic [14:0] left_m1;
		logic [7:0]  want;
		logic        good;
		header_step_d = header_step_q;
		in_payload_d  = in_payload_q;
		length_d      = length_q;
		bytes_left_d  = bytes_left_q;
		type_d        = type_q;
		flags_d       = flags_q;
		xor_d         = xor_q;
		err_d         = err_q;
		emit          = 1'b0;
		left_m1       = bytes_left_q - 15'd1;
		good          = (xor_q == step_byte);
		case (header_step_q[1:0])
			2'd0:    want = cfg.sync_word[31:24];
			2'd1:    want = cfg.sync_word[23:16];
			2'd2:    want = cfg.sync_word[15:8];
			default: want = cfg.sync_word[7:0];
		endcase
		res_d.kind        = slxd_pkg::KIND_DATA;
		res_d.data        = step_byte;
		res_d.pkt_type    = type_q;
		res_d.pkt_flags   = flags_q;
		res_d.pkt_length  = length_q[14:0];
		res_d.error_total = err_q;
		res_d.last        = 1'b0;
		if (in_payload_q) begin
			emit         = 1'b1;
			bytes_left_d = left_m1;
			if (left_m1 != 15'd0) begin
				xor_d = xor_q ^ step_byte;
			end else begin
				if (!good && err_q != 16'hFFFF) begin
					err_d = err_q + 16'd1;
				end
				res_d.kind        = good ? slxd_pkg::KIND_GOOD : slxd_pkg::KIND_BAD;
				res_d.last        = 1'b1;
				res_d.error_total = err_d;
				header_step_d     = 3'd0;
				in_payload_d      = 1'b0;
			end
		end else begin
			case (header_step_q)
				slxd_pkg::HDR_LEN_LO: begin
					length_d      = {8'd0, step_byte};
					xor_d         = step_byte;
					header_step_d = slxd_pkg::HDR_LEN_HI;
				end
				slxd_pkg::HDR_LEN_HI: begin
					length_d      = {step_byte, length_q[7:0]};
					xor_d         = xor_q ^ step_byte;
					header_step_d = slxd_pkg::HDR_TYPE;
				end
				slxd_pkg::HDR_TYPE: begin
					type_d        = step_byte;
					xor_d         = xor_q ^ step_byte;
					header_step_d = slxd_pkg::HDR_FLAGS;
				end
				slxd_pkg::HDR_FLAGS: begin
					header_step_d = 3'd0;
					if (length_q != 16'd0 && !length_q[15]
					    && length_q[14:0] <= cfg.max_length) begin
						flags_d      = step_byte;
						xor_d        = xor_q ^ step_byte;
						bytes_left_d = length_q[14:0];
						in_payload_d = 1'b1;
					end
				end
				default: begin
					if (step_byte == want) begin
						header_step_d = header_step_q + 3'd1;
					end else begin
						header_step_d = 3'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_step_q <= 3'd0;
			in_payload_q  <= 1'b0;
			length_q      <= 16'd0;
			bytes_left_q  <= 15'd0;
			type_q        <= 8'd0;
			flags_q       <= 8'd0;
			xor_q         <= 8'd0;
			err_q         <= 16'd0;
		end else if (step_valid && advance) begin
			header_step_q <= header_step_d;
			in_payload_q  <= in_payload_d;
			length_q      <= length_d;
			bytes_left_q  <= bytes_left_d;
			type_q        <= type_d;
			flags_q       <= flags_d;
			xor_q         <= xor_d;
			err_q         <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= step_valid & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid && emit) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

endmodule

[rtl/core/sync_length_xor_packet_deframer.sv]
// Sync-word, length-prefixed packet deframer with XOR checksum (top level).
// Depends on slxd_pkg, slxd_apb_regs and slxd_parser.
//
// Input channel: one received byte per transaction on rx_byte, taken when
// in_valid is high and in_stall is low. Output channel: one result per
// payload byte (out_kind data) and one at packet end (good or checksum
// error, frame_last high), taken when out_valid is high and out_stall low.
// Header bytes and dropped bytes produce no result.
// A byte is registered at the input, then parsed from the input register, and
// any result it gives is registered in the output register as the output advances.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// parser state update between the input register and the output register.
// When the receiver stalls, the output register holds its result; an empty
// input register takes at most one more byte, then in_stall rises until the result is taken.
// Reset clears the parser to sync hunting, the error count to zero and loads
// the sync word 0xAA558844 and maximum length 4000. The APB port (pready
// always high) holds the sync word at address 0 and max length at 4.
// Write registers only while the block is idle.
module sync_length_xor_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic [7:0]  pkt_type,
	output logic [7:0]  pkt_flags,
	output logic [14:0] pkt_length,
	output logic [15:0] error_total,
	output logic        frame_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	slxd_pkg::cfg_t    cfg;
	slxd_pkg::result_t res;
	logic              res_valid;
	logic              advance;
	logic              byte_valid_s1;
	logic [7:0]        byte_s1;

	slxd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = !res_valid || !out_stall;
	assign in_stall = byte_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	slxd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step_valid (byte_valid_s1),
		.step_byte  (byte_s1),
		.advance    (advance),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign out_valid   = res_valid;
	assign out_kind    = res.kind;
	assign out_byte    = res.data;
	assign pkt_type    = res.pkt_type;
	assign pkt_flags   = res.pkt_flags;
	assign pkt_length  = res.pkt_length;
	assign error_total = res.error_total;
	assign frame_last  = res.last;

endmodule

[rtl/core/slxd_checker.sv]
// Port-level assertions for the deframer and the bind that attaches them.
// Depends on slxd_pkg and sync_length_xor_packet_deframer_macros.svh.
`include "sync_length_xor_packet_deframer_macros.svh"

module slxd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  out_kind,
	input  logic [7:0]  out_byte,
	input  logic [15:0] error_total,
	input  logic        frame_last
);

	`SLXD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_byte) && $stable(out_kind), "stalled result changed")

	`SLXD_ASSERT_NOW(a_last_kind, clk, arst_n, out_valid,
		frame_last == (out_kind != slxd_pkg::KIND_DATA), "frame_last disagrees with kind")

	`SLXD_ASSERT_NOW(a_kind_code, clk, arst_n, out_valid,
		out_kind == slxd_pkg::KIND_DATA || out_kind == slxd_pkg::KIND_GOOD ||
		out_kind == slxd_pkg::KIND_BAD, "unknown result kind")

	`SLXD_ASSERT_NEXT(a_err_monotonic, clk, arst_n, out_valid && !out_stall,
		!out_valid || error_total >= $past(error_total), "error count went down")

endmodule

bind sync_length_xor_packet_deframer slxd_checker u_slxd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_kind    (out_kind),
	.out_byte    (out_byte),
	.error_total (error_total),
	.frame_last  (frame_last)
);

[bench/slxd_frame_checker.sv]
// Transaction checker for the sync/length/XOR packet deframer: snoops the
// byte channel, the result channel and the APB writes, and predicts each result.
// Depends on slxd_pkg.
`timescale 1ns / 100ps

module slxd_frame_checker
	import slxd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  out_kind,
	input  logic [7:0]  out_byte,
	input  logic [7:0]  pkt_type,
	input  logic [7:0]  pkt_flags,
	input  logic [14:0] pkt_length,
	input  logic [15:0] error_total,
	input  logic        frame_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          pending_count
);

	cfg_t        cur_cfg;
	logic [2:0]  hdr_pos;
	logic        in_frame;
	logic [15:0] len_field;
	logic [14:0] bytes_left;
	logic [7:0]  cur_type;
	logic [7:0]  cur_flags;
	logic [7:0]  xor_acc;
	logic [15:0] err_count;
	result_t     pending_results[$];
	int          mismatches = 0;

	assign mismatch_count = mismatches;

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp);
		if (got !== exp)
			report($sformatf("%s: got %0h, expected %0h", name, got, exp));
	endtask

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			report($sformatf("result with no transaction pending: kind %0d byte %02h",
				out_kind, out_byte));
		end else begin
			want = pending_results.pop_front();
			check_field("out_kind", 16'(out_kind), 16'(want.kind));
			check_field("out_byte", 16'(out_byte), 16'(want.data));
			check_field("pkt_type", 16'(pkt_type), 16'(want.pkt_type));
			check_field("pkt_flags", 16'(pkt_flags), 16'(want.pkt_flags));
			check_field("pkt_length", 16'(pkt_length), 16'(want.pkt_length));
			check_field("error_total", error_total, want.error_total);
			check_field("frame_last", 16'(frame_last), 16'(want.last));
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		result_t r;
		logic [7:0] want;
		if (in_frame) begin
			bytes_left = bytes_left - 15'd1;
			if (bytes_left != 15'd0) begin
				xor_acc = xor_acc ^ b;
				r.kind = KIND_DATA;
				r.last = 1'b0;
			end else begin
				if (xor_acc != b && err_count != 16'hFFFF)
					err_count = err_count + 16'd1;
				r.kind = (xor_acc == b) ? KIND_GOOD : KIND_BAD;
				r.last = 1'b1;
				in_frame = 1'b0;
				hdr_pos = 3'd0;
			end
			r.data = b;
			r.pkt_type = cur_type;
			r.pkt_flags = cur_flags;
			r.pkt_length = len_field[14:0];
			r.error_total = err_count;
			pending_results.push_back(r);
		end else begin
			case (hdr_pos)
				HDR_LEN_LO: begin
					len_field = {8'd0, b};
					xor_acc = b;
					hdr_pos = HDR_LEN_HI;
				end
				HDR_LEN_HI: begin
					len_field[15:8] = b;
					xor_acc = xor_acc ^ b;
					hdr_pos = HDR_TYPE;
				end
				HDR_TYPE: begin
					cur_type = b;
					xor_acc = xor_acc ^ b;
					hdr_pos = HDR_FLAGS;
				end
				HDR_FLAGS: begin
					if (len_field != 16'd0 && !len_field[15]
							&& len_field[14:0] <= cur_cfg.max_length) begin
						cur_flags = b;
						xor_acc = xor_acc ^ b;
						bytes_left = len_field[14:0];
						in_frame = 1'b1;
					end
					hdr_pos = 3'd0;
				end
				default: begin
					want = 8'(cur_cfg.sync_word >> (24 - 8 * hdr_pos[1:0]));
					hdr_pos = (b == want) ? hdr_pos + 3'd1 : 3'd0;
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cfg.sync_word = SYNC_RESET;
			cur_cfg.max_length = MAXLEN_RESET;
			hdr_pos = 3'd0;
			in_frame = 1'b0;
			len_field = 16'd0;
			bytes_left = 15'd0;
			cur_type = 8'd0;
			cur_flags = 8'd0;
			xor_acc = 8'd0;
			err_count = 16'd0;
			pending_results.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_SYNC, 2'b00})
					cur_cfg.sync_word = pwdata;
				else if (paddr == {REG_MAXLEN, 2'b00})
					cur_cfg.max_length = pwdata[14:0];
			end
			if (in_valid && !in_stall)
				deframe_byte(rx_byte);
			pending_count <= pending_results.size();
		end
	end

endmodule

[bench/sync_length_xor_packet_deframer_tb.sv]
// Testbench top for the sync/length/XOR packet deframer: drives byte streams,
// frames and register settings, and gives the verdict.
// Depends on slxd_pkg, the deframer RTL and slxd_frame_checker.
`timescale 1ns / 100ps

module sync_length_xor_packet_deframer_tb;
	import slxd_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 115;
	localparam int NUM_PHASES   = 6;
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [7:0]  pkt_type;
	logic [7:0]  pkt_flags;
	logic [14:0] pkt_length;
	logic [15:0] error_total;
	logic        frame_last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int          mismatch_count;
	int          pending_count;
	int          quiet_cycles = 0;
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          frame_items = 0;
	logic [31:0] sync_now = SYNC_RESET;
	logic [14:0] maxlen_now = MAXLEN_RESET;

	sync_length_xor_packet_deframer DUT (.*);

	slxd_frame_checker checker_i (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("sync_length_xor_packet_deframer: mismatch");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_SYNC)
			sync_now = value;
		else
			maxlen_now = value[14:0];
	endtask

	// hold the input until every expected result is out, then let the pipe drain
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame(input logic [15:0] len, input logic [7:0] typ,
			input logic [7:0] flg, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		int i;
		for (i = 0; i < 4; i++)
			send_byte(sync_now[8 * (3 - i) +: 8]);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		send_byte(typ);
		send_byte(flg);
		frame_items += 8;
		sum = len[7:0] ^ len[15:8] ^ typ ^ flg;
		if (len != 16'd0 && !len[15] && len[14:0] <= maxlen_now) begin
			for (i = 1; i < int'(len); i++) begin
				b = 8'($urandom_range(255));
				sum ^= b;
				send_byte(b);
			end
			if (corrupt)
				sum ^= 8'($urandom_range(1, 255));
			send_byte(sum);
			frame_items += int'(len);
		end
	endtask

	function automatic logic [15:0] pick_length();
		int sel;
		int lim;
		sel = $urandom_range(15);
		lim = (sel == 4) ? 60 : 10;
		if (lim > int'(maxlen_now))
			lim = int'(maxlen_now);
		case (sel)
			0: return 16'd0;
			1: return {1'b1, 15'($urandom)};
			2: return {1'b0, maxlen_now} + 16'd1;
			3: return (maxlen_now <= 15'd60) ? {1'b0, maxlen_now} : 16'(lim);
			default: return 16'($urandom_range(1, lim));
		endcase
	endfunction

	initial begin
		int phase;
		int k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 58; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 58; end
				default: begin send_gap_pct = 16; recv_stall_pct = 16; end
			endcase
			case (phase)
				0: begin apb_write(REG_SYNC, SYNC_RESET); apb_write(REG_MAXLEN, 32'(MAXLEN_RESET)); end
				1: begin apb_write(REG_SYNC, 32'hFFFF_FFFF); apb_write(REG_MAXLEN, 32'd1); end
				2: begin apb_write(REG_SYNC, 32'h0000_0000); apb_write(REG_MAXLEN, 32'd32767); end
				3: begin apb_write(REG_SYNC, $urandom); apb_write(REG_MAXLEN, $urandom_range(2, 40)); end
				4: begin apb_write(REG_SYNC, $urandom); apb_write(REG_MAXLEN, $urandom_range(1, 20)); end
				default: begin apb_write(REG_SYNC, $urandom); apb_write(REG_MAXLEN, 32'd32767); end
			endcase
			frame_items = 0;
			if (phase == 0) begin
				send_frame(16'd1, 8'hFF, 8'h00, 1'b0);
				// first sync byte twice: the repeat is dropped, not retried
				send_byte(sync_now[31:24]);
				send_byte(sync_now[31:24]);
				send_frame(16'd2, 8'h00, 8'hFF, 1'b1);
				send_frame(16'd0, 8'h5A, 8'hA5, 1'b0);
			end
			while (frame_items < PHASE_ITEMS) begin
				case ($urandom_range(9))
					0: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
					1: begin
						k = $urandom_range(1, 3);
						for (int i = 0; i < k; i++)
							send_byte(sync_now[8 * (3 - i) +: 8]);
					end
					default: ;
				endcase
				send_frame(pick_length(), 8'($urandom_range(255)), 8'($urandom_range(255)),
					$urandom_range(4) == 0);
			end
			drain();
		end
		if (mismatch_count == 0 && pending_count == 0)
			$display("sync_length_xor_packet_deframer: match");
		else
			$display("sync_length_xor_packet_deframer: mismatch");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/slxd_pkg.sv
rtl/core/slxd_apb_regs.sv
rtl/core/slxd_parser.sv
rtl/core/sync_length_xor_packet_deframer.sv
rtl/core/slxd_checker.sv
bench/slxd_frame_checker.sv
bench/sync_length_xor_packet_deframer_tb.sv
